>>> hw/rtl/spws_pkg.sv
// Package: shared types, constants and register indexes for the watering sequencer.
package spws_pkg;

    localparam int RAW_W      = 12;
    localparam int THRESH_W   = 7;
    localparam int TICKS_W    = 24;
    localparam int STAGE_W    = 3;
    localparam int LEVEL_W    = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 16;
    localparam int PROD_W     = 19;

    localparam logic [RAW_W-1:0]   RAW_FULL_SCALE = 12'd4095;
    localparam logic [6:0]         PERCENT_SCALE  = 7'd100;
    localparam logic [TICKS_W-1:0] TICKS_MAX      = 24'hFFFFFF;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MOISTURE_THRESHOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_STAGE_TWO     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_STAGE_THREE   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_STAGE_FOUR    = 4'd3;

    localparam logic [THRESH_W-1:0] THRESH_RESET     = 7'd40;
    localparam logic [TICKS_W-1:0]  WAIT_TWO_RESET   = 24'd15000;
    localparam logic [TICKS_W-1:0]  WAIT_THREE_RESET = 24'd20000;
    localparam logic [TICKS_W-1:0]  WAIT_FOUR_RESET  = 24'd30000;

    typedef struct packed {
        logic [THRESH_W-1:0] moisture_threshold;
        logic [TICKS_W-1:0]  wait_stage_two;
        logic [TICKS_W-1:0]  wait_stage_three;
        logic [TICKS_W-1:0]  wait_stage_four;
    } cfg_t;

    typedef struct packed {
        logic             tick;
        logic             button_press;
        logic [RAW_W-1:0] moisture_raw;
        logic             below_low_mark;
        logic             below_high_mark;
    } item_t;

    typedef struct packed {
        logic               soil_dry;
        logic [LEVEL_W-1:0] tank_level;
    } sense_t;

    typedef struct packed {
        logic               request_latched;
        logic               ready_flag;
        logic [LEVEL_W-1:0] tank_level;
        logic               soil_dry;
        logic [STAGE_W-1:0] stage;
        logic               pump_on;
    } result_t;

endpackage

>>> hw/rtl/spws_cfg.sv
// Configuration register file for threshold and stage wait times.
module spws_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [spws_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spws_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output spws_pkg::cfg_t                   cfg
);

    spws_pkg::cfg_t cfg_reg;
    spws_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                spws_pkg::REG_MOISTURE_THRESHOLD:
                    cfg_next.moisture_threshold = cfg_wdata[spws_pkg::THRESH_W-1:0];
                spws_pkg::REG_WAIT_STAGE_TWO:
                    cfg_next.wait_stage_two = cfg_wdata[spws_pkg::TICKS_W-1:0];
                spws_pkg::REG_WAIT_STAGE_THREE:
                    cfg_next.wait_stage_three = cfg_wdata[spws_pkg::TICKS_W-1:0];
                spws_pkg::REG_WAIT_STAGE_FOUR:
                    cfg_next.wait_stage_four = cfg_wdata[spws_pkg::TICKS_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.moisture_threshold <= spws_pkg::THRESH_RESET;
            cfg_reg.wait_stage_two     <= spws_pkg::WAIT_TWO_RESET;
            cfg_reg.wait_stage_three   <= spws_pkg::WAIT_THREE_RESET;
            cfg_reg.wait_stage_four    <= spws_pkg::WAIT_FOUR_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/spws_sense.sv
// Sensor evaluation: tank level sum and soil dryness compare.
module spws_sense (
    input  spws_pkg::item_t                  item,
    input  logic [spws_pkg::THRESH_W-1:0]    moisture_threshold,
    output spws_pkg::sense_t                 sense
);

    logic [spws_pkg::RAW_W-1:0]  wetness;
    logic [spws_pkg::PROD_W-1:0] wet_scaled;
    logic [spws_pkg::PROD_W-1:0] thresh_scaled;

    always_comb begin
        wetness       = spws_pkg::RAW_FULL_SCALE - item.moisture_raw;
        wet_scaled    = spws_pkg::PROD_W'(wetness) * spws_pkg::PROD_W'(spws_pkg::PERCENT_SCALE);
        thresh_scaled = spws_pkg::PROD_W'(moisture_threshold)
                      * spws_pkg::PROD_W'(spws_pkg::RAW_FULL_SCALE);
        sense.soil_dry   = !(wet_scaled > thresh_scaled);
        sense.tank_level = spws_pkg::LEVEL_W'(item.below_high_mark)
                         + spws_pkg::LEVEL_W'(item.below_low_mark);
    end

endmodule

>>> hw/rtl/spws_seq.sv
// Stage sequencer: request latch, tick counter, stage and pump control.
module spws_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  spws_pkg::item_t   item,
    input  spws_pkg::sense_t  sense,
    input  spws_pkg::cfg_t    cfg,
    output spws_pkg::result_t result
);

    typedef enum logic [spws_pkg::STAGE_W-1:0] {
        ST_IDLE  = 3'd0,
        ST_DRAIN = 3'd1,
        ST_TWO   = 3'd2,
        ST_THREE = 3'd3,
        ST_FOUR  = 3'd4
    } stage_t;

    stage_t                       stage_reg, stage_next;
    logic                         pump_reg, pump_next;
    logic [spws_pkg::TICKS_W-1:0] elapsed_reg, elapsed_next;
    logic                         request_reg, request_next;
    logic                         ready_reg, ready_next;
    logic [spws_pkg::TICKS_W-1:0] wait_sel;
    logic                         tank_full;
    logic                         tank_empty;

    always_comb begin
        tank_full  = (sense.tank_level == spws_pkg::LEVEL_FULL);
        tank_empty = (sense.tank_level == spws_pkg::LEVEL_EMPTY);

        request_next = request_reg | (item.button_press & ready_reg);
        ready_next   = sense.soil_dry & tank_full;

        elapsed_next = elapsed_reg;
        if (item.tick && (elapsed_reg != spws_pkg::TICKS_MAX)) begin
            elapsed_next = elapsed_reg + spws_pkg::TICKS_W'(1);
        end

        stage_next = stage_reg;
        if (ready_next && request_next) begin
            stage_next = ST_DRAIN;
        end
        pump_next = pump_reg;

        unique case (stage_next)
            ST_TWO:   wait_sel = cfg.wait_stage_two;
            ST_THREE: wait_sel = cfg.wait_stage_three;
            default:  wait_sel = cfg.wait_stage_four;
        endcase

        unique case (stage_next) inside
            ST_DRAIN: begin
                if (tank_full) begin
                    pump_next = 1'b1;
                end else if (tank_empty) begin
                    pump_next    = 1'b0;
                    elapsed_next = '0;
                    stage_next   = ST_TWO;
                end
            end
            ST_TWO, ST_THREE, ST_FOUR: begin
                if (elapsed_next >= wait_sel) begin
                    if (!tank_empty) begin
                        pump_next = 1'b1;
                    end else begin
                        pump_next    = 1'b0;
                        elapsed_next = '0;
                        if (stage_next == ST_FOUR) begin
                            stage_next   = ST_IDLE;
                            request_next = 1'b0;
                        end else if (stage_next == ST_TWO) begin
                            stage_next = ST_THREE;
                        end else begin
                            stage_next = ST_FOUR;
                        end
                    end
                end
            end
            default: begin
                pump_next = pump_reg;
            end
        endcase

        result.pump_on         = pump_next;
        result.stage           = stage_next;
        result.soil_dry        = sense.soil_dry;
        result.tank_level      = sense.tank_level;
        result.ready_flag      = ready_next;
        result.request_latched = request_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg   <= ST_IDLE;
            pump_reg    <= 1'b0;
            elapsed_reg <= '0;
            request_reg <= 1'b0;
            ready_reg   <= 1'b0;
        end else if (advance) begin
            stage_reg   <= stage_next;
            pump_reg    <= pump_next;
            elapsed_reg <= elapsed_next;
            request_reg <= request_next;
            ready_reg   <= ready_next;
        end
    end

endmodule

>>> hw/rtl/staged_pump_watering_sequencer.sv
// Top level: staged pump watering sequencer with stream input and result channels.
//
// Usage:
//   s_ words carry one sensor sample each: tank switches, soil reading,
//   button flag and time tick. m_ words carry one result per sample:
//   pump drive, stage, dryness, tank level, ready flag and request latch.
//   cfg_wr_en/cfg_index/cfg_wdata write the threshold and the three stage
//   waits; write them only while no word is in flight.
// Path: a word accepted on s_ is registered in the input register,
//   evaluated, and moved into the result register when the result side
//   is free; m_ presents it from the result register.
// Throughput: one word per cycle unless m_ stalls; the sequencer state
//   updates in the same cycle the evaluated word enters the result register.
// Reset: aresetn low at a clock edge empties both registers, returns the
//   sequencer to idle with the pump off, and restores default settings.
// Stall: while m_tready is low the result word holds; one more word waits
//   in the input register, then s_tready drops until the result is taken.
module staged_pump_watering_sequencer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [0] below_high_mark, [1] below_low_mark, [13:2] moisture_raw,
    // [14] button_press, [15] tick
    input  logic [spws_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] pump_on, [3:1] stage, [4] soil_dry, [6:5] tank_level,
    // [7] ready_flag, [8] request_latched, [15:9] zero
    output logic [spws_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [spws_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spws_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int ItemW = $bits(spws_pkg::item_t);
    localparam int ResW  = $bits(spws_pkg::result_t);

    logic              in_valid_reg;
    spws_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    spws_pkg::result_t out_res_reg;
    logic              advance;
    spws_pkg::cfg_t    cfg;
    spws_pkg::sense_t  sense;
    spws_pkg::result_t result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    spws_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    spws_sense u_sense (
        .item               (in_item_reg),
        .moisture_threshold (cfg.moisture_threshold),
        .sense              (sense)
    );

    spws_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .sense   (sense),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= spws_pkg::item_t'(s_tdata[ItemW-1:0]);
        end
        if (advance) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(spws_pkg::M_DATA_W-ResW){1'b0}}, out_res_reg};

endmodule

>>> hw/rtl/spws_checker.sv
// Port checker for the watering sequencer, bound to the top level.
module spws_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [spws_pkg::M_DATA_W-1:0]   m_tdata
);

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word dropped or changed");

    a_stage_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3:1] <= 3'd4 && m_tdata[6:5] != 2'd3)
        else $error("stage or tank level out of range");

    a_ready_means_full_dry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7] |-> m_tdata[6:5] == 2'd0 && m_tdata[4])
        else $error("ready flag without full tank and dry soil");

    a_drain_pump_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:1] == 3'd1 && m_tdata[6:5] == 2'd0 |-> m_tdata[0])
        else $error("pump off in drain stage with full tank");

endmodule

bind staged_pump_watering_sequencer spws_checker u_spws_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> test/tb_staged_pump_watering_sequencer.sv
// Testbench: self-checking stream test of the staged pump watering sequencer.
module tb_staged_pump_watering_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT     = 400000;
    localparam int          PHASE_WORDS     = 255;
    localparam int          PHASE_COUNT     = 6;
    localparam int          SETTLE_CYCLES   = 6;
    localparam logic [spws_pkg::CFG_IDX_W-1:0] REG_SPARE = 4'd12;

    localparam logic [spws_pkg::STAGE_W-1:0] STAGE_IDLE  = 3'd0;
    localparam logic [spws_pkg::STAGE_W-1:0] STAGE_FILL  = 3'd1;
    localparam logic [spws_pkg::STAGE_W-1:0] STAGE_TWO   = 3'd2;
    localparam logic [spws_pkg::STAGE_W-1:0] STAGE_THREE = 3'd3;
    localparam logic [spws_pkg::STAGE_W-1:0] STAGE_FOUR  = 3'd4;

    typedef struct {
        spws_pkg::item_t   word;
        bit                typed;
        spws_pkg::result_t want;
    } row_t;

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [spws_pkg::S_DATA_W-1:0]   s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [spws_pkg::M_DATA_W-1:0]   m_tdata;
    logic                            cfg_wr_en = 1'b0;
    logic [spws_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [spws_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // sequencer mirror
    logic [spws_pkg::STAGE_W-1:0]  seq_stage;
    logic                          seq_pump;
    logic [spws_pkg::TICKS_W-1:0]  seq_elapsed;
    logic                          seq_request;
    logic                          seq_ready;
    logic [spws_pkg::THRESH_W-1:0] set_thresh;
    logic [spws_pkg::TICKS_W-1:0]  set_wait_two;
    logic [spws_pkg::TICKS_W-1:0]  set_wait_three;
    logic [spws_pkg::TICKS_W-1:0]  set_wait_four;

    spws_pkg::result_t pending_results[$];
    row_t              directed_rows[$];
    int                send_idle_pct;
    int                recv_idle_pct;
    int                tank_sim;
    int                err_count;
    int                words_sent;
    int                results_seen;
    int                pump_on_seen;
    int                stage_seen[8];
    int                cycle_count;

    staged_pump_watering_sequencer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic spws_pkg::result_t water_step(spws_pkg::item_t w);
        logic [spws_pkg::LEVEL_W-1:0] lvl;
        logic                         dry;
        logic                         rdy;
        logic [31:0]                  lhs;
        logic [31:0]                  rhs;
        logic [spws_pkg::TICKS_W-1:0] lim;
        spws_pkg::result_t            r;
        lvl = {1'b0, w.below_high_mark} + {1'b0, w.below_low_mark};
        if (w.button_press && seq_ready) seq_request = 1'b1;
        lhs = (32'd4095 - {20'd0, w.moisture_raw}) * 32'd100;
        rhs = {25'd0, set_thresh} * 32'd4095;
        dry = !(lhs > rhs);
        rdy = dry && (lvl == spws_pkg::LEVEL_FULL);
        seq_ready = rdy;
        if (w.tick && seq_elapsed != spws_pkg::TICKS_MAX)
            seq_elapsed = seq_elapsed + spws_pkg::TICKS_W'(1);
        if (rdy && seq_request) seq_stage = STAGE_FILL;
        if (seq_stage == STAGE_FILL) begin
            if (lvl == spws_pkg::LEVEL_FULL) begin
                seq_pump = 1'b1;
            end else if (lvl == spws_pkg::LEVEL_EMPTY) begin
                seq_pump    = 1'b0;
                seq_elapsed = '0;
                seq_stage   = STAGE_TWO;
            end
        end else if (seq_stage >= STAGE_TWO && seq_stage <= STAGE_FOUR) begin
            lim = (seq_stage == STAGE_TWO)   ? set_wait_two :
                  (seq_stage == STAGE_THREE) ? set_wait_three : set_wait_four;
            if (seq_elapsed >= lim) begin
                if (lvl != spws_pkg::LEVEL_EMPTY) begin
                    seq_pump = 1'b1;
                end else begin
                    seq_pump    = 1'b0;
                    seq_elapsed = '0;
                    if (seq_stage == STAGE_FOUR) begin
                        seq_stage   = STAGE_IDLE;
                        seq_request = 1'b0;
                    end else begin
                        seq_stage = seq_stage + spws_pkg::STAGE_W'(1);
                    end
                end
            end
        end
        r.pump_on         = seq_pump;
        r.stage           = seq_stage;
        r.soil_dry        = dry;
        r.tank_level      = lvl;
        r.ready_flag      = seq_ready;
        r.request_latched = seq_request;
        return r;
    endfunction

    function automatic spws_pkg::result_t result_of(bit pump,
                                                    logic [spws_pkg::STAGE_W-1:0] stg,
                                                    bit dry,
                                                    logic [spws_pkg::LEVEL_W-1:0] lvl,
                                                    bit rdy, bit req);
        spws_pkg::result_t r;
        r.pump_on         = pump;
        r.stage           = stg;
        r.soil_dry        = dry;
        r.tank_level      = lvl;
        r.ready_flag      = rdy;
        r.request_latched = req;
        return r;
    endfunction

    function automatic spws_pkg::item_t sample_of(bit hi, bit lo, int raw, bit btn, bit tk);
        spws_pkg::item_t w;
        w.below_high_mark = hi;
        w.below_low_mark  = lo;
        w.moisture_raw    = raw[spws_pkg::RAW_W-1:0];
        w.button_press    = btn;
        w.tick            = tk;
        return w;
    endfunction

    task automatic add_row(bit hi, bit lo, int raw, bit btn, bit tk,
                           bit typed = 1'b0, spws_pkg::result_t want = '0);
        row_t row;
        row.word  = sample_of(hi, lo, raw, btn, tk);
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // plausible tank/soil/button sequence, with some raw noise
    function automatic spws_pkg::item_t next_sample();
        spws_pkg::item_t w;
        int              min_dry;
        int              raw;
        int              pick;
        bit              hi;
        bit              lo;
        if ($urandom_range(0, 99) < 10) return spws_pkg::item_t'(16'($urandom));
        if ($urandom_range(0, 99) < 25) tank_sim = $urandom_range(0, 2);
        case (tank_sim)
            0: begin
                hi = 1'b0;
                lo = 1'b0;
            end
            1: begin
                hi = 1'($urandom_range(0, 1));
                lo = !hi;
            end
            default: begin
                hi = 1'b1;
                lo = 1'b1;
            end
        endcase
        min_dry = 4095 - (int'(set_thresh) * 4095) / 100;
        if (min_dry < 0) min_dry = 0;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            raw = min_dry + int'($urandom_range(0, 4)) - 2;
            if (raw < 0) raw = 0;
            if (raw > 4095) raw = 4095;
        end else if (pick < 80 || min_dry == 0) begin
            raw = $urandom_range(min_dry, 4095);
        end else begin
            raw = $urandom_range(0, min_dry - 1);
        end
        w = sample_of(hi, lo, raw, $urandom_range(0, 99) < 20, $urandom_range(0, 99) < 70);
        return w;
    endfunction

    task automatic send_word(spws_pkg::item_t w, bit typed, spws_pkg::result_t want);
        spws_pkg::result_t pred;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = water_step(w);
        pending_results.push_back(typed ? want : pred);
        words_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [spws_pkg::CFG_IDX_W-1:0] idx,
                             logic [spws_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic program_settings(logic [spws_pkg::THRESH_W-1:0] thr,
                                    logic [spws_pkg::TICKS_W-1:0] w2,
                                    logic [spws_pkg::TICKS_W-1:0] w3,
                                    logic [spws_pkg::TICKS_W-1:0] w4);
        cfg_write(spws_pkg::REG_MOISTURE_THRESHOLD, {17'($urandom), thr});
        cfg_write(spws_pkg::REG_WAIT_STAGE_TWO, w2);
        cfg_write(spws_pkg::REG_WAIT_STAGE_THREE, w3);
        cfg_write(spws_pkg::REG_WAIT_STAGE_FOUR, w4);
        cfg_write(REG_SPARE, 24'($urandom));
        cfg_wr_en      <= 1'b0;
        set_thresh     = thr;
        set_wait_two   = w2;
        set_wait_three = w3;
        set_wait_four  = w4;
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        spws_pkg::result_t got;
        spws_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = spws_pkg::result_t'(m_tdata[8:0]);
            results_seen++;
            stage_seen[got.stage]++;
            if (got.pump_on) pump_on_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none actual %h",
                         $time, m_tdata);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("pump_on", want.pump_on, got.pump_on);
                check_field("stage", want.stage, got.stage);
                check_field("soil_dry", want.soil_dry, got.soil_dry);
                check_field("tank_level", want.tank_level, got.tank_level);
                check_field("ready_flag", want.ready_flag, got.ready_flag);
                check_field("request_latched", want.request_latched,
                            got.request_latched);
                check_field("pad", 0, int'(m_tdata[spws_pkg::M_DATA_W-1:9]));
            end
        end
    end

    initial begin
        logic [spws_pkg::THRESH_W-1:0] thr;
        logic [spws_pkg::TICKS_W-1:0]  w2;
        logic [spws_pkg::TICKS_W-1:0]  w3;
        logic [spws_pkg::TICKS_W-1:0]  w4;
        cycle_count    = 0;
        err_count      = 0;
        words_sent     = 0;
        results_seen   = 0;
        pump_on_seen   = 0;
        tank_sim       = 0;
        foreach (stage_seen[i]) stage_seen[i] = 0;
        send_idle_pct  = 17;
        recv_idle_pct  = 70;
        seq_stage      = STAGE_IDLE;
        seq_pump       = 1'b0;
        seq_elapsed    = '0;
        seq_request    = 1'b0;
        seq_ready      = 1'b0;
        set_thresh     = spws_pkg::THRESH_RESET;
        set_wait_two   = spws_pkg::WAIT_TWO_RESET;
        set_wait_three = spws_pkg::WAIT_THREE_RESET;
        set_wait_four  = spws_pkg::WAIT_FOUR_RESET;

        // button right after reset is ignored: no ready yet
        add_row(0, 0, 4095, 1, 0, 1, result_of(0, STAGE_IDLE, 1, 2'd0, 1, 0));
        add_row(0, 0, 4095, 1, 1, 1, result_of(1, STAGE_FILL, 1, 2'd0, 1, 1));
        add_row(1, 0, 4095, 0, 1, 1, result_of(1, STAGE_FILL, 1, 2'd1, 0, 1));
        add_row(0, 1, 2456, 0, 0);
        add_row(1, 1, 0, 0, 1, 1, result_of(0, STAGE_TWO, 0, 2'd2, 0, 1));
        add_row(0, 0, 2457, 0, 1);
        add_row(0, 0, 2456, 0, 0);
        add_row(1, 1, 4095, 1, 1);
        add_row(0, 1, 4095, 0, 1);
        add_row(1, 0, 2048, 1, 1);
        add_row(1, 1, 1, 0, 1);
        add_row(0, 0, 4094, 1, 0);
        add_row(1, 1, 4095, 0, 0);
        add_row(0, 0, 0, 1, 0);
        add_row(0, 0, 4095, 0, 1);
        add_row(1, 0, 4095, 1, 1);
        add_row(0, 0, 1365, 0, 1);
        add_row(1, 1, 2730, 1, 0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
        drain();

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph / 2)
                0: begin
                    send_idle_pct = 17;
                    recv_idle_pct = 70;
                end
                1: begin
                    send_idle_pct = 70;
                    recv_idle_pct = 17;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (ph)
                0: begin
                    thr = 7'd40;  w2 = 24'd2;        w3 = 24'd3;        w4 = 24'd1;
                end
                1: begin
                    thr = 7'd0;   w2 = 24'd0;        w3 = 24'd0;        w4 = 24'd0;
                end
                2: begin
                    thr = 7'd100; w2 = 24'd1;        w3 = 24'd0;        w4 = 24'd4;
                end
                3: begin
                    thr = 7'd127; w2 = spws_pkg::TICKS_MAX; w3 = 24'd5; w4 = 24'd0;
                end
                4: begin
                    thr = 7'($urandom_range(0, 127));
                    w2  = 24'($urandom_range(0, 8));
                    w3  = 24'($urandom_range(0, 8));
                    w4  = 24'($urandom_range(0, 8));
                end
                default: begin
                    thr = 7'($urandom_range(0, 100));
                    w2  = 24'($urandom_range(0, 3));
                    w3  = spws_pkg::TICKS_MAX;
                    w4  = spws_pkg::TICKS_MAX;
                end
            endcase
            program_settings(thr, w2, w3, w4);
            for (int n = 0; n < PHASE_WORDS; n++) send_word(next_sample(), 1'b0, '0);
            drain();
        end

        $display("sent %0d sensor words over %0d settings, checked %0d results",
                 words_sent, PHASE_COUNT + 1, results_seen);
        $display("stage hits idle/1/2/3/4: %0d/%0d/%0d/%0d/%0d, pump on in %0d results",
                 stage_seen[0], stage_seen[1], stage_seen[2], stage_seen[3],
                 stage_seen[4], pump_on_seen);
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
